// ----- design/pfa_pkg.sv -----
// shared types and constants for the page frame allocator
`default_nettype none

package pfa_pkg;

   localparam int FUNC_W   = 2;
   localparam int COUNT_W  = 6;
   localparam int INDEX_W  = 10;
   localparam int FRAME_W  = 10;
   localparam int STATUS_W = 2;
   localparam int RUN_W    = 6;
   localparam int WORD_W   = RUN_W + 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int LFSR_W   = 16;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED     = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_ROOM = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD     = 2'd2;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_CLEAN = 2'd1,
      ST_DIRTY = 2'd2,
      ST_FIXED = 2'd3
   } frame_state_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_INIT   = 2'd0,
      FN_KALLOC = 2'd1,
      FN_UALLOC = 2'd2,
      FN_FREE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      SM_FREE     = 2'd0,
      SM_NONFIXED = 2'd1,
      SM_USED     = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      WP_ZERO = 2'd0,
      WP_SCAN = 2'd1,
      WP_IDX  = 2'd2
   } wp_src_type;

   typedef enum logic [1:0] {
      W_ZERO   = 2'd0,
      W_INIT   = 2'd1,
      W_KFIX   = 2'd2,
      W_UDIRTY = 2'd3
   } wsel_type;

   typedef enum logic [1:0] {
      RS_ZERO  = 2'd0,
      RS_FOUND = 2'd1,
      RS_WP    = 2'd2,
      RS_IDX   = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic                load_req;
      logic                scan_go;
      scan_mode_type       scan_mode;
      logic                scan_one;
      logic                scan_from_rem;
      logic                wp_load;
      wp_src_type          wp_src;
      logic                wp_inc;
      logic                cnt_from_run;
      logic                first_save;
      logic                lfsr_seed;
      logic                lfsr_step;
      logic                we;
      wsel_type            wsel;
      logic                emit;
      logic                emit_final;
      logic [STATUS_W-1:0] status;
      res_sel_type         res_sel;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     cnt_bad;
      logic     idx_bad;
      logic     run_zero;
      logic     rd_used;
      logic     wp_last;
      logic     wp_end;
      logic     k_last;
      logic     scan_done;
      logic     scan_found;
      logic     div_done;
      logic     out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/page_frame_allocator_core.sv -----
// page frame allocator top level: map of frame states and run lengths
// Requests come in on req_* (valid/stall) with func, page_count and frame_index;
// results leave on rsp_* (valid/stall). Each request gives zero or more eviction
// notices (kind 0) and then one final answer (kind 1, last 1).
// Registers are written on csr_* (valid/ready, always ready); the user is to write them
// only while idle, which the block itself leaves unchecked. One request is worked on
// at a time; req_stall is high otherwise.
// The cost is set by the frame scan, one map memory read per cycle, and by the
// read/modify of each frame of a run; the victim offset is computed in a bit-serial
// remainder unit.
// After reset the map is cleared one frame a cycle while req_stall stays high;
// registers take their reset values at once.
// A stalled receiver holds the result register; the block waits before the
// next notice or answer, so no result is lost.
`default_nettype none

module page_frame_allocator_core #(
   parameter int FRAMES  = 1024,
   parameter int MAX_RUN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pfa_pkg::FUNC_W-1:0]      req_func,
   input  logic [pfa_pkg::COUNT_W-1:0]     req_page_count,
   input  logic [pfa_pkg::INDEX_W-1:0]     req_frame_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [pfa_pkg::FRAME_W-1:0]     rsp_frame,
   output logic                            rsp_was_dirty,
   output logic [pfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pfa_pkg::cmd_type  cmd;
   pfa_pkg::stat_type stat;
   logic              csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfa_dpath #(
      .FRAMES  (FRAMES),
      .MAX_RUN (MAX_RUN)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_func),
      .req_page_count  (req_page_count),
      .req_frame_index (req_frame_index),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_frame       (rsp_frame),
      .rsp_was_dirty   (rsp_was_dirty),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ----- design/pfa_dpath.sv -----
// datapath: frame map memory, scanner, modulo unit, lfsr, registers and result register
`default_nettype none

module pfa_dpath #(
   parameter int FRAMES  = 1024,
   parameter int MAX_RUN = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [pfa_pkg::FUNC_W-1:0]       req_func,
   input  logic [pfa_pkg::COUNT_W-1:0]      req_page_count,
   input  logic [pfa_pkg::INDEX_W-1:0]      req_frame_index,
   input  pfa_pkg::cmd_type                 cmd,
   output pfa_pkg::stat_type                stat,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic                             rsp_kind,
   output logic [pfa_pkg::FRAME_W-1:0]      rsp_frame,
   output logic                             rsp_was_dirty,
   output logic [pfa_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_last
);

   localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int NW = $clog2(FRAMES + 1);
   localparam int RW = NW + 1;
   localparam int RUN_W = pfa_pkg::RUN_W;
   localparam int LW = pfa_pkg::LFSR_W;

   // configuration registers
   logic [10:0]   fiu_ff;
   logic [10:0]   rsv_ff;
   logic [LW-1:0] seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff  <= 11'd1024;
         rsv_ff  <= 11'd1;
         seed_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            pfa_pkg::CSR_FRAMES_IN_USE:   fiu_ff  <= csr_wdata[10:0];
            pfa_pkg::CSR_RESERVED_FRAMES: rsv_ff  <= csr_wdata[10:0];
            pfa_pkg::CSR_RANDOM_SEED:     seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request registers
   logic [pfa_pkg::FUNC_W-1:0]  func_ff;
   logic [RUN_W-1:0]            cnt_ff;
   logic [pfa_pkg::INDEX_W-1:0] idx_ff;
   logic [NW-1:0]               n_ff;
   logic [NW-1:0]               n_in;
   logic [31:0]                 fiu32;

   assign fiu32 = 32'(fiu_ff);
   assign n_in  = (fiu32 < 32'(FRAMES)) ? NW'(fiu32) : NW'(FRAMES);

   // map memory: {run length, frame state}
   logic [pfa_pkg::WORD_W-1:0] mem [FRAMES];
   logic [pfa_pkg::WORD_W-1:0] rdata_ff;
   logic [pfa_pkg::WORD_W-1:0] wdata;
   logic [AW-1:0]              raddr;
   pfa_pkg::frame_state_type   rd_st;
   logic [RUN_W-1:0]           rd_run;

   assign rd_st  = pfa_pkg::frame_state_type'(rdata_ff[1:0]);
   assign rd_run = rdata_ff[pfa_pkg::WORD_W-1:2];

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         cnt_ff  <= req_page_count;
         idx_ff  <= req_frame_index;
         n_ff    <= n_in;
      end else if (cmd.cnt_from_run) begin
         cnt_ff <= rd_run;
      end
   end

   // write pointer and step counter
   logic [AW-1:0]    wp_ff;
   logic [RUN_W-1:0] k_ff;
   logic             init_fixed;

   // scanner
   logic                   scanning_ff;
   logic [NW-1:0]          ptr_ff;
   logic [RUN_W-1:0]       run_ff;
   logic [RUN_W-1:0]       scnt_ff;
   pfa_pkg::scan_mode_type smode_ff;
   logic                   rd_vld_ff;
   logic [NW-1:0]          rd_idx_ff;
   logic                   done_ff;
   logic                   found_ff;
   logic [AW-1:0]          found_idx_ff;
   logic [AW-1:0]          first_cd_ff;
   logic                   ok;
   logic                   hit;
   logic                   exhausted;
   logic [RUN_W-1:0]       run_in;

   // modulo unit and lfsr
   logic [LW-1:0]  lfsr_ff;
   logic [LW-1:0]  lfsr_in;
   logic [LW-1:0]  dvd_ff;
   logic [RW-1:0]  rem_ff;
   logic [RW-1:0]  trial;
   logic [4:0]     dcnt_ff;
   logic           div_busy_ff;
   logic           div_done_ff;

   assign raddr = scanning_ff ? ptr_ff[AW-1:0] : wp_ff;

   assign init_fixed = (32'(wp_ff) < 32'(n_ff)) && (32'(wp_ff) < 32'(rsv_ff));

   always_comb begin
      case (cmd.wsel)
         pfa_pkg::W_INIT:
            wdata = init_fixed ? {RUN_W'(1), pfa_pkg::ST_FIXED} : '0;
         pfa_pkg::W_KFIX:   wdata = {cnt_ff, pfa_pkg::ST_FIXED};
         pfa_pkg::W_UDIRTY: wdata = {RUN_W'(1), pfa_pkg::ST_DIRTY};
         default:           wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[wp_ff] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         k_ff  <= '0;
      end else if (cmd.wp_load) begin
         k_ff <= '0;
         case (cmd.wp_src)
            pfa_pkg::WP_SCAN: wp_ff <= found_ff ? found_idx_ff : first_cd_ff;
            pfa_pkg::WP_IDX:  wp_ff <= AW'(idx_ff);
            default:          wp_ff <= '0;
         endcase
      end else if (cmd.wp_inc) begin
         wp_ff <= wp_ff + AW'(1);
         k_ff  <= k_ff + RUN_W'(1);
      end
   end

   always_comb begin
      case (smode_ff)
         pfa_pkg::SM_FREE:     ok = (rd_st == pfa_pkg::ST_FREE);
         pfa_pkg::SM_NONFIXED: ok = (rd_st != pfa_pkg::ST_FIXED);
         default:              ok = (rd_st == pfa_pkg::ST_CLEAN) ||
                                    (rd_st == pfa_pkg::ST_DIRTY);
      endcase
   end

   assign run_in    = ok ? run_ff + RUN_W'(1) : '0;
   assign hit       = scanning_ff && rd_vld_ff && ok && (run_ff + RUN_W'(1) == scnt_ff);
   assign exhausted = scanning_ff && !rd_vld_ff && !(ptr_ff < n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.scan_go) begin
            scanning_ff <= 1'b1;
            rd_vld_ff   <= 1'b0;
            found_ff    <= 1'b0;
         end else if (scanning_ff) begin
            if (hit || exhausted) begin
               scanning_ff <= 1'b0;
               rd_vld_ff   <= 1'b0;
               done_ff     <= 1'b1;
               found_ff    <= hit;
            end else begin
               rd_vld_ff <= (ptr_ff < n_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_go) begin
         ptr_ff   <= cmd.scan_from_rem ? rem_ff[NW-1:0] : '0;
         run_ff   <= '0;
         scnt_ff  <= cmd.scan_one ? RUN_W'(1) : cnt_ff;
         smode_ff <= cmd.scan_mode;
      end else if (scanning_ff) begin
         if (ptr_ff < n_ff) begin
            rd_idx_ff <= ptr_ff;
            ptr_ff    <= ptr_ff + NW'(1);
         end
         if (rd_vld_ff) begin
            run_ff <= run_in;
         end
      end
      if (hit) begin
         found_idx_ff <= AW'(rd_idx_ff + NW'(1) - NW'(scnt_ff));
      end
      if (cmd.first_save) begin
         first_cd_ff <= found_idx_ff;
      end
   end

   // galois lfsr, one step per victim choice
   assign lfsr_in = {1'b0, lfsr_ff[LW-1:1]} ^ (lfsr_ff[0] ? pfa_pkg::LFSR_TAPS : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= 16'd1;
      end else if (cmd.lfsr_seed) begin
         lfsr_ff <= (seed_ff == '0) ? 16'd1 : seed_ff;
      end else if (cmd.lfsr_step) begin
         lfsr_ff <= lfsr_in;
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign trial = {rem_ff[RW-2:0], dvd_ff[LW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         dcnt_ff     <= '0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.lfsr_step) begin
            div_busy_ff <= 1'b1;
            dcnt_ff     <= 5'(LW);
         end else if (div_busy_ff) begin
            dcnt_ff <= dcnt_ff - 5'd1;
            if (dcnt_ff == 5'd1) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lfsr_step) begin
         dvd_ff <= lfsr_in;
         rem_ff <= '0;
      end else if (div_busy_ff) begin
         dvd_ff <= {dvd_ff[LW-2:0], 1'b0};
         rem_ff <= (trial >= {1'b0, n_ff}) ? trial - {1'b0, n_ff} : trial;
      end
   end

   // result register
   logic                          out_free;
   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic [pfa_pkg::FRAME_W-1:0]   rsp_frame_ff;
   logic                          rsp_dirty_ff;
   logic [pfa_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic                          rsp_last_ff;
   logic [pfa_pkg::FRAME_W-1:0]   res_frame;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.res_sel)
         pfa_pkg::RS_FOUND: res_frame = pfa_pkg::FRAME_W'(found_idx_ff);
         pfa_pkg::RS_WP:    res_frame = pfa_pkg::FRAME_W'(wp_ff);
         pfa_pkg::RS_IDX:   res_frame = pfa_pkg::FRAME_W'(idx_ff);
         default:           res_frame = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_final;
         rsp_frame_ff  <= cmd.emit_final ? res_frame : pfa_pkg::FRAME_W'(wp_ff);
         rsp_dirty_ff  <= !cmd.emit_final && (rd_st == pfa_pkg::ST_DIRTY);
         rsp_status_ff <= cmd.emit_final ? cmd.status : pfa_pkg::STAT_OK;
         rsp_last_ff   <= cmd.emit_final;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_frame     = rsp_frame_ff;
   assign rsp_was_dirty = rsp_dirty_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // status to the controller
   assign stat.func       = pfa_pkg::func_type'(func_ff);
   assign stat.cnt_bad    = (cnt_ff == '0) || (32'(cnt_ff) > 32'(MAX_RUN));
   assign stat.idx_bad    = 32'(idx_ff) >= 32'(n_ff);
   assign stat.run_zero   = (rd_run == '0);
   assign stat.rd_used    = (rd_st == pfa_pkg::ST_CLEAN) || (rd_st == pfa_pkg::ST_DIRTY);
   assign stat.wp_last    = (wp_ff == AW'(FRAMES - 1));
   assign stat.wp_end     = (32'(wp_ff) + 32'd1 == 32'(n_ff));
   assign stat.k_last     = (k_ff + RUN_W'(1) == cnt_ff);
   assign stat.scan_done  = done_ff;
   assign stat.scan_found = found_ff;
   assign stat.div_done   = div_done_ff;
   assign stat.out_free   = out_free;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result overwritten while still waiting");

   a_scan_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_go |-> !scanning_ff)
      else $error("scan restarted while running");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (scanning_ff && rd_vld_ff) |-> (rd_idx_ff < n_ff))
      else $error("scan read beyond map size");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.lfsr_step |-> !div_busy_ff)
      else $error("modulo started while busy");

endmodule

`default_nettype wire

// ----- design/pfa_ctrl.sv -----
// controller state machine sequencing each request over the datapath
`default_nettype none

module pfa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pfa_pkg::stat_type  stat,
   output pfa_pkg::cmd_type   cmd
);

   typedef enum logic [18:0] {
      S_CLEAR  = 19'd1 << 0,
      S_IDLE   = 19'd1 << 1,
      S_DISP   = 19'd1 << 2,
      S_INIT   = 19'd1 << 3,
      S_KSCAN1 = 19'd1 << 4,
      S_KSCAN2 = 19'd1 << 5,
      S_EVRD   = 19'd1 << 6,
      S_EVCHK  = 19'd1 << 7,
      S_USCAN1 = 19'd1 << 8,
      S_USCAN2 = 19'd1 << 9,
      S_UDIV   = 19'd1 << 10,
      S_USCAN3 = 19'd1 << 11,
      S_UEVRD  = 19'd1 << 12,
      S_UEVCHK = 19'd1 << 13,
      S_UWR    = 19'd1 << 14,
      S_FRD    = 19'd1 << 15,
      S_FCHK   = 19'd1 << 16,
      S_FWR    = 19'd1 << 17,
      S_FINAL  = 19'd1 << 18
   } state_type;

   state_type                     state_ff;
   state_type                     state_in;
   logic [pfa_pkg::STATUS_W-1:0]  status_ff;
   logic [pfa_pkg::STATUS_W-1:0]  status_in;
   pfa_pkg::res_sel_type          rsel_ff;
   pfa_pkg::res_sel_type          rsel_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      rsel_in   = rsel_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.we   = 1'b1;
            cmd.wsel = pfa_pkg::W_ZERO;
            if (stat.wp_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.wp_inc = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.func)
               pfa_pkg::FN_INIT: begin
                  cmd.wp_load   = 1'b1;
                  cmd.wp_src    = pfa_pkg::WP_ZERO;
                  cmd.lfsr_seed = 1'b1;
                  state_in      = S_INIT;
               end
               pfa_pkg::FN_KALLOC: begin
                  if (stat.cnt_bad) begin
                     status_in = pfa_pkg::STAT_BAD;
                     rsel_in   = pfa_pkg::RS_ZERO;
                     state_in  = S_FINAL;
                  end else begin
                     cmd.scan_go   = 1'b1;
                     cmd.scan_mode = pfa_pkg::SM_FREE;
                     state_in      = S_KSCAN1;
                  end
               end
               pfa_pkg::FN_UALLOC: begin
                  cmd.scan_go   = 1'b1;
                  cmd.scan_mode = pfa_pkg::SM_FREE;
                  cmd.scan_one  = 1'b1;
                  state_in      = S_USCAN1;
               end
               default: begin
                  if (stat.idx_bad) begin
                     status_in = pfa_pkg::STAT_BAD;
                     rsel_in   = pfa_pkg::RS_ZERO;
                     state_in  = S_FINAL;
                  end else begin
                     cmd.wp_load = 1'b1;
                     cmd.wp_src  = pfa_pkg::WP_IDX;
                     state_in    = S_FRD;
                  end
               end
            endcase
         end
         S_INIT: begin
            cmd.we   = 1'b1;
            cmd.wsel = pfa_pkg::W_INIT;
            if (stat.wp_last) begin
               status_in = pfa_pkg::STAT_OK;
               rsel_in   = pfa_pkg::RS_ZERO;
               state_in  = S_FINAL;
            end else begin
               cmd.wp_inc = 1'b1;
            end
         end
         S_KSCAN1: begin
            if (stat.scan_done) begin
               if (stat.scan_found) begin
                  cmd.wp_load = 1'b1;
                  cmd.wp_src  = pfa_pkg::WP_SCAN;
                  state_in    = S_EVRD;
               end else begin
                  // no free run: retry over frames that are not fixed
                  cmd.scan_go   = 1'b1;
                  cmd.scan_mode = pfa_pkg::SM_NONFIXED;
                  state_in      = S_KSCAN2;
               end
            end
         end
         S_KSCAN2: begin
            if (stat.scan_done) begin
               if (stat.scan_found) begin
                  cmd.wp_load = 1'b1;
                  cmd.wp_src  = pfa_pkg::WP_SCAN;
                  state_in    = S_EVRD;
               end else begin
                  status_in = pfa_pkg::STAT_NO_ROOM;
                  rsel_in   = pfa_pkg::RS_ZERO;
                  state_in  = S_FINAL;
               end
            end
         end
         S_EVRD: begin
            state_in = S_EVCHK;
         end
         S_EVCHK: begin
            if (!stat.rd_used || stat.out_free) begin
               cmd.emit = stat.rd_used;
               cmd.we   = 1'b1;
               cmd.wsel = pfa_pkg::W_KFIX;
               if (stat.k_last) begin
                  status_in = pfa_pkg::STAT_OK;
                  rsel_in   = pfa_pkg::RS_FOUND;
                  state_in  = S_FINAL;
               end else begin
                  cmd.wp_inc = 1'b1;
                  state_in   = S_EVRD;
               end
            end
         end
         S_USCAN1: begin
            if (stat.scan_done) begin
               if (stat.scan_found) begin
                  cmd.wp_load = 1'b1;
                  cmd.wp_src  = pfa_pkg::WP_SCAN;
                  state_in    = S_UWR;
               end else begin
                  cmd.scan_go   = 1'b1;
                  cmd.scan_mode = pfa_pkg::SM_USED;
                  cmd.scan_one  = 1'b1;
                  state_in      = S_USCAN2;
               end
            end
         end
         S_USCAN2: begin
            // first used frame doubles as the wrap-around victim
            if (stat.scan_done) begin
               if (stat.scan_found) begin
                  cmd.first_save = 1'b1;
                  cmd.lfsr_step  = 1'b1;
                  state_in       = S_UDIV;
               end else begin
                  status_in = pfa_pkg::STAT_NO_ROOM;
                  rsel_in   = pfa_pkg::RS_ZERO;
                  state_in  = S_FINAL;
               end
            end
         end
         S_UDIV: begin
            if (stat.div_done) begin
               cmd.scan_go       = 1'b1;
               cmd.scan_mode     = pfa_pkg::SM_USED;
               cmd.scan_one      = 1'b1;
               cmd.scan_from_rem = 1'b1;
               state_in          = S_USCAN3;
            end
         end
         S_USCAN3: begin
            if (stat.scan_done) begin
               cmd.wp_load = 1'b1;
               cmd.wp_src  = pfa_pkg::WP_SCAN;
               state_in    = S_UEVRD;
            end
         end
         S_UEVRD: begin
            state_in = S_UEVCHK;
         end
         S_UEVCHK: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_UWR;
            end
         end
         S_UWR: begin
            cmd.we    = 1'b1;
            cmd.wsel  = pfa_pkg::W_UDIRTY;
            status_in = pfa_pkg::STAT_OK;
            rsel_in   = pfa_pkg::RS_WP;
            state_in  = S_FINAL;
         end
         S_FRD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (stat.run_zero) begin
               status_in = pfa_pkg::STAT_BAD;
               rsel_in   = pfa_pkg::RS_ZERO;
               state_in  = S_FINAL;
            end else begin
               cmd.cnt_from_run = 1'b1;
               state_in         = S_FWR;
            end
         end
         S_FWR: begin
            cmd.we   = 1'b1;
            cmd.wsel = pfa_pkg::W_ZERO;
            // run is cut at the end of the map
            if (stat.k_last || stat.wp_end) begin
               status_in = pfa_pkg::STAT_OK;
               rsel_in   = pfa_pkg::RS_IDX;
               state_in  = S_FINAL;
            end else begin
               cmd.wp_inc = 1'b1;
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_final = 1'b1;
               cmd.status     = status_ff;
               cmd.res_sel    = rsel_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         status_ff <= pfa_pkg::STAT_OK;
         rsel_ff   <= pfa_pkg::RS_ZERO;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         rsel_ff   <= rsel_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the page frame allocator core
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAMES    = 1024;
   localparam int MAX_RUN   = 32;
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD = 2000;
   localparam logic KIND_NOTICE = 1'b0;
   localparam logic KIND_FINAL  = 1'b1;

   typedef struct {
      logic                         kind;
      logic [pfa_pkg::FRAME_W-1:0]  frame;
      logic                         dirty;
      logic [pfa_pkg::STATUS_W-1:0] status;
      logic                         last;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [pfa_pkg::FUNC_W-1:0] req_func = '0;
   logic [pfa_pkg::COUNT_W-1:0] req_page_count = '0;
   logic [pfa_pkg::INDEX_W-1:0] req_frame_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic [pfa_pkg::FRAME_W-1:0] rsp_frame;
   logic rsp_was_dirty;
   logic [pfa_pkg::STATUS_W-1:0] rsp_status;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pfa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pfa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // copy of the map kept by the testbench
   pfa_pkg::frame_state_type map_st [FRAMES];
   logic [pfa_pkg::RUN_W-1:0] map_run [FRAMES];
   logic [pfa_pkg::LFSR_W-1:0] lfsr_q;
   logic [10:0] cfg_frames;
   logic [10:0] cfg_reserved;
   logic [15:0] cfg_seed;

   answer_type answer_q[$];
   bit failed = 0;
   bit gaps_on = 1;
   bit quiet = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_cnt = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   page_frame_allocator_core #(.FRAMES(FRAMES), .MAX_RUN(MAX_RUN)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_page_count(req_page_count), .req_frame_index(req_frame_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_frame(rsp_frame), .rsp_was_dirty(rsp_was_dirty),
      .rsp_status(rsp_status), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned map_size();
      return (cfg_frames < FRAMES) ? cfg_frames : FRAMES;
   endfunction

   function automatic void push_answer(logic kind, int unsigned frame, logic dirty,
                                       logic [pfa_pkg::STATUS_W-1:0] status);
      answer_type a;
      a.kind = kind;
      a.frame = frame[pfa_pkg::FRAME_W-1:0];
      a.dirty = dirty;
      a.status = status;
      a.last = kind;
      answer_q.push_back(a);
   endfunction

   function automatic void evict_frame(int unsigned f);
      if (map_st[f] == pfa_pkg::ST_CLEAN || map_st[f] == pfa_pkg::ST_DIRTY) begin
         push_answer(KIND_NOTICE, f, map_st[f] == pfa_pkg::ST_DIRTY, pfa_pkg::STAT_OK);
         map_st[f] = pfa_pkg::ST_CLEAN;
      end
   endfunction

   // lowest window of cnt frames passing the test, n when there is none
   function automatic int unsigned lowest_window(int unsigned n, int unsigned cnt,
                                                 bit only_free);
      int unsigned run;
      bit ok;
      run = 0;
      for (int unsigned i = 0; i < n; i++) begin
         ok = only_free ? (map_st[i] == pfa_pkg::ST_FREE)
                        : (map_st[i] != pfa_pkg::ST_FIXED);
         run = ok ? run + 1 : 0;
         if (run == cnt) return i + 1 - cnt;
      end
      return n;
   endfunction

   function automatic void predict_request(pfa_pkg::func_type f,
                                           logic [pfa_pkg::COUNT_W-1:0] cnt,
                                           logic [pfa_pkg::INDEX_W-1:0] idx);
      int unsigned n, start, pos, len;
      bit any;
      bit lsb;
      n = map_size();
      case (f)
         pfa_pkg::FN_INIT: begin
            for (int unsigned i = 0; i < FRAMES; i++) begin
               if (i < n && i < cfg_reserved) begin
                  map_st[i] = pfa_pkg::ST_FIXED;
                  map_run[i] = 1;
               end else begin
                  map_st[i] = pfa_pkg::ST_FREE;
                  map_run[i] = 0;
               end
            end
            lfsr_q = (cfg_seed == 0) ? 16'd1 : cfg_seed;
            push_answer(KIND_FINAL, 0, 1'b0, pfa_pkg::STAT_OK);
         end
         pfa_pkg::FN_KALLOC: begin
            if (cnt == 0 || cnt > MAX_RUN) begin
               push_answer(KIND_FINAL, 0, 1'b0, pfa_pkg::STAT_BAD);
            end else begin
               start = lowest_window(n, cnt, 1'b1);
               if (start >= n) start = lowest_window(n, cnt, 1'b0);
               if (start >= n) begin
                  push_answer(KIND_FINAL, 0, 1'b0, pfa_pkg::STAT_NO_ROOM);
               end else begin
                  for (int unsigned i = start; i < start + cnt; i++) evict_frame(i);
                  for (int unsigned i = start; i < start + cnt; i++) begin
                     map_st[i] = pfa_pkg::ST_FIXED;
                     map_run[i] = cnt;
                  end
                  push_answer(KIND_FINAL, start, 1'b0, pfa_pkg::STAT_OK);
               end
            end
         end
         pfa_pkg::FN_UALLOC: begin
            start = lowest_window(n, 1, 1'b1);
            any = 1'b1;
            if (start >= n) begin
               any = 1'b0;
               for (int unsigned i = 0; i < n; i++)
                  if (map_st[i] == pfa_pkg::ST_CLEAN || map_st[i] == pfa_pkg::ST_DIRTY)
                     any = 1'b1;
               if (any) begin
                  lsb = lfsr_q[0];
                  lfsr_q = lfsr_q >> 1;
                  if (lsb) lfsr_q = lfsr_q ^ pfa_pkg::LFSR_TAPS;
                  pos = lfsr_q % n;
                  for (int unsigned i = 0; i < n; i++) begin
                     if (map_st[pos] == pfa_pkg::ST_CLEAN ||
                         map_st[pos] == pfa_pkg::ST_DIRTY) break;
                     pos = (pos + 1 == n) ? 0 : pos + 1;
                  end
                  start = pos;
                  evict_frame(start);
               end
            end
            if (!any) begin
               push_answer(KIND_FINAL, 0, 1'b0, pfa_pkg::STAT_NO_ROOM);
            end else begin
               map_st[start] = pfa_pkg::ST_DIRTY;
               map_run[start] = 1;
               push_answer(KIND_FINAL, start, 1'b0, pfa_pkg::STAT_OK);
            end
         end
         default: begin
            if (idx >= n || map_run[idx] == 0) begin
               push_answer(KIND_FINAL, 0, 1'b0, pfa_pkg::STAT_BAD);
            end else begin
               len = map_run[idx];
               for (int unsigned i = idx; i < idx + len && i < n; i++) begin
                  map_st[i] = pfa_pkg::ST_FREE;
                  map_run[i] = 0;
               end
               push_answer(KIND_FINAL, idx, 1'b0, pfa_pkg::STAT_OK);
            end
         end
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            $error("unexpected result: kind %0d frame %0d status %0d",
                   rsp_kind, rsp_frame, rsp_status);
            failed = 1;
         end else begin
            a = answer_q.pop_front();
            if (rsp_kind !== a.kind) begin
               $error("kind: expected %0d, got %0d", a.kind, rsp_kind);
               failed = 1;
            end
            if (rsp_frame !== a.frame) begin
               $error("frame: expected %0d, got %0d", a.frame, rsp_frame);
               failed = 1;
            end
            if (rsp_was_dirty !== a.dirty) begin
               $error("was_dirty: expected %0d, got %0d", a.dirty, rsp_was_dirty);
               failed = 1;
            end
            if (rsp_status !== a.status) begin
               $error("status: expected %0d, got %0d", a.status, rsp_status);
               failed = 1;
            end
            if (rsp_last !== a.last) begin
               $error("last: expected %0d, got %0d", a.last, rsp_last);
               failed = 1;
            end
         end
      end
   end

   // receiver stall: random bursts, plus a long counted hold on demand
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_cnt <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("page_frame_allocator_core: mismatch");
         $finish;
      end
   end

   task automatic send_request(pfa_pkg::func_type f, int cnt, int idx);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_page_count <= cnt[pfa_pkg::COUNT_W-1:0];
      req_frame_index <= idx[pfa_pkg::INDEX_W-1:0];
      do @(posedge clock); while (req_stall);
      predict_request(f, cnt[pfa_pkg::COUNT_W-1:0], idx[pfa_pkg::INDEX_W-1:0]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [pfa_pkg::CSR_IDX_W-1:0] index, int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[pfa_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (index)
         pfa_pkg::CSR_FRAMES_IN_USE:   cfg_frames = value[10:0];
         pfa_pkg::CSR_RESERVED_FRAMES: cfg_reserved = value[10:0];
         default:                      cfg_seed = value[15:0];
      endcase
   endtask

   task automatic set_config(int frames, int reserved, int seed);
      wait_drained();
      write_reg(pfa_pkg::CSR_FRAMES_IN_USE, frames);
      write_reg(pfa_pkg::CSR_RESERVED_FRAMES, reserved);
      write_reg(pfa_pkg::CSR_RANDOM_SEED, seed);
      csr_valid <= 1'b0;
      send_request(pfa_pkg::FN_INIT, $urandom_range(0, 63), $urandom_range(0, 1023));
   endtask

   function automatic int pick_start();
      int unsigned n, f;
      n = map_size();
      for (int t = 0; t < 64; t++) begin
         f = $urandom_range(0, n - 1);
         if (map_run[f] != 0) return f;
      end
      return $urandom_range(0, 1023);
   endfunction

   task automatic random_request();
      int r, cnt, idx;
      r = $urandom_range(0, 99);
      cnt = $urandom_range(0, 9) < 8 ? $urandom_range(1, 8) : $urandom_range(0, 63);
      idx = $urandom_range(0, 9) < 7 ? pick_start() : $urandom_range(0, 1023);
      if (r < 4)       send_request(pfa_pkg::FN_INIT, cnt, idx);
      else if (r < 40) send_request(pfa_pkg::FN_KALLOC, cnt, idx);
      else if (r < 70) send_request(pfa_pkg::FN_UALLOC, cnt, idx);
      else             send_request(pfa_pkg::FN_FREE, cnt, idx);
   endtask

   task automatic test_default_map();
      send_request(pfa_pkg::FN_UALLOC, 0, 0);
      send_request(pfa_pkg::FN_FREE, 0, 0);
      send_request(pfa_pkg::FN_INIT, 0, 0);
      send_request(pfa_pkg::FN_KALLOC, 0, 0);
      send_request(pfa_pkg::FN_KALLOC, 33, 0);
      send_request(pfa_pkg::FN_KALLOC, 63, 1023);
      send_request(pfa_pkg::FN_KALLOC, 32, 0);
      send_request(pfa_pkg::FN_KALLOC, 1, 0);
      send_request(pfa_pkg::FN_UALLOC, 0, 0);
      send_request(pfa_pkg::FN_FREE, 0, 1);
      send_request(pfa_pkg::FN_FREE, 0, 2);
      send_request(pfa_pkg::FN_FREE, 0, 1023);
   endtask

   task automatic test_eviction();
      // seed zero falls back to one; small map so it fills quickly
      set_config(8, 0, 0);
      repeat (9) send_request(pfa_pkg::FN_UALLOC, 0, 0);
      send_request(pfa_pkg::FN_KALLOC, 3, 0);
      send_request(pfa_pkg::FN_KALLOC, 1, 0);
      send_request(pfa_pkg::FN_KALLOC, 8, 0);
      send_request(pfa_pkg::FN_FREE, 0, 9);
      send_request(pfa_pkg::FN_KALLOC, 2, 0);
      send_request(pfa_pkg::FN_FREE, 0, 6);
   endtask

   task automatic test_reserved_beyond_map();
      set_config(4, 1024, 65535);
      send_request(pfa_pkg::FN_UALLOC, 0, 0);
      send_request(pfa_pkg::FN_KALLOC, 1, 0);
      send_request(pfa_pkg::FN_FREE, 0, 0);
      send_request(pfa_pkg::FN_FREE, 0, 4);
   endtask

   task automatic test_random(int frames, int reserved, int seed, int count);
      set_config(frames, reserved, seed);
      repeat (count) random_request();
   endtask

   task automatic test_backpressure();
      set_config(16, 2, $urandom_range(1, 65535));
      hold_req++;
      repeat (8) random_request();
      wait_drained();
      repeat (10) random_request();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
         map_st[i] = pfa_pkg::ST_FREE;
         map_run[i] = 0;
      end
      lfsr_q = 16'd1;
      cfg_frames = 11'd1024;
      cfg_reserved = 11'd1;
      cfg_seed = 16'd1;
      test_default_map();
      test_eviction();
      test_reserved_beyond_map();
      test_random(1, 0, $urandom_range(1, 65535), 15);
      test_random(12, 1, $urandom_range(1, 65535), 45);
      test_random(40, 3, $urandom_range(1, 65535), 45);
      test_backpressure();
      test_random(1024, 0, $urandom_range(1, 65535), 25);
      test_random(700, 690, $urandom_range(1, 65535), 30);
      gaps_on = 0;
      quiet = 1;
      test_random(24, 4, $urandom_range(1, 65535), 40);
      wait_drained();
      repeat (50) @(posedge clock);
      if (!failed)
         $display("page_frame_allocator_core: match");
      else
         $display("page_frame_allocator_core: mismatch");
      $finish;
   end

endmodule

// ----- page_frame_allocator_core.f -----
design/pfa_pkg.sv
design/pfa_dpath.sv
design/pfa_ctrl.sv
design/page_frame_allocator_core.sv
tb/tb_top.sv
